@@ rtl/vtp_pkg.sv @@
`default_nettype none
package vtp_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_ROT_X     = 4'd0;
    localparam logic [3:0] REG_ROT_Y     = 4'd1;
    localparam logic [3:0] REG_ROT_Z     = 4'd2;
    localparam logic [3:0] REG_TRANS     = 4'd3;
    localparam logic [3:0] REG_X_SCALE   = 4'd4;
    localparam logic [3:0] REG_Y_SCALE   = 4'd5;
    localparam logic [3:0] REG_DEPTH_OFS = 4'd6;
    localparam logic [3:0] REG_DEPTH_NUM = 4'd7;

    localparam logic [47:0] ROT_X_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_Y_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_Z_RESET = 48'h4000_0000_0000;

    // Fixed bias subtracted from the translated depth.
    localparam logic [15:0] TZ_BIAS = 16'd12288;

    // The long divider retires DIV_BITS quotient bits per stage.
    localparam int DIV_WIDTH  = 32;
    localparam int DIV_BITS   = 8;
    localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [5:0]  rz;
        logic               zero;
    } t_view;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] work;
        logic [4:0]           rem;
    } t_div_lane;

    typedef struct packed {
        logic [5:0] dvs;
        logic       neg_x;
        logic       neg_y;
        logic       neg_d;
        logic       zero;
    } t_div_ctl;

    typedef struct packed {
        t_div_lane lx;
        t_div_lane ly;
        t_div_lane ld;
        t_div_ctl  ctl;
    } t_div_pack;

endpackage
`default_nettype wire

@@ rtl/vtp_vert_if.sv @@
`default_nettype none
interface vtp_vert_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] vert_z;

    modport source (output valid, output vert_x, output vert_y, output vert_z, input ready);
    modport sink (input valid, input vert_x, input vert_y, input vert_z, output ready);
endinterface
`default_nettype wire

@@ rtl/vtp_proj_if.sv @@
`default_nettype none
interface vtp_proj_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] depth_out;
    logic               depth_zero;

    modport source (output valid, output screen_x, output screen_y, output depth_out,
                    output depth_zero, input ready);
    modport sink (input valid, input screen_x, input screen_y, input depth_out,
                  input depth_zero, output ready);
endinterface
`default_nettype wire

@@ rtl/vtp_rotate.sv @@
`default_nettype none
module vtp_rotate
    import vtp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_z,
    input  wire logic [47:0]        i_row_x,
    input  wire logic [47:0]        i_row_y,
    input  wire logic [47:0]        i_row_z,
    input  wire logic [47:0]        i_trans,
    output logic                    o_vld,
    output t_view                   o_view
);

    logic signed [15:0] vin  [3];
    logic        [47:0] rows [3];
    logic signed [31:0] r_prod [3][3];
    logic               r_vld1;
    logic               r_vld2;
    t_view              r_view;
    t_view              n_view;
    logic signed [34:0] sum [3];
    logic        [15:0] pz;

    assign vin[0]  = i_x;
    assign vin[1]  = i_y;
    assign vin[2]  = i_z;
    assign rows[0] = i_row_x;
    assign rows[1] = i_row_y;
    assign rows[2] = i_row_z;

    // First stage: nine 16x16 coefficient products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= 32'(vin[c]) * 32'($signed(rows[r][16*c +: 16]));
                end
            end
        end
    end

    // Second stage: row sums, Q14 scaling of the x and y rows, translation and 16-bit wrap.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = 35'(r_prod[r][0]) + 35'(r_prod[r][1]) + (35'(r_prod[r][2]) <<< 2);
        end
        n_view.px   = sum[0][29:14] + {i_trans[4:0], 11'b0};
        n_view.py   = sum[1][29:14] + {i_trans[20:16], 11'b0};
        // The depth row is scaled by 2^-16 and carries the fixed bias.
        pz          = sum[2][31:16] + {i_trans[38:32], 9'b0} - TZ_BIAS;
        n_view.rz   = pz[15:10];
        n_view.zero = (pz[15:10] == 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_view <= n_view;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_view = r_view;

endmodule
`default_nettype wire

@@ rtl/vtp_scale.sv @@
`default_nettype none
module vtp_scale
    import vtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire t_view       i_view,
    input  wire logic [15:0] i_x_scale,
    input  wire logic [15:0] i_y_scale,
    input  wire logic [31:0] i_depth_num,
    output logic             o_vld,
    output t_div_pack        o_pack
);

    logic signed [32:0] r_mx;
    logic signed [32:0] r_my;
    t_view              r_view;
    logic               r_vld3;
    logic               r_vld4;
    t_div_pack          r_pack;
    t_div_pack          n_pack;
    logic signed [21:0] sx;
    logic signed [21:0] sy;
    logic        [21:0] ax;
    logic        [21:0] ay;
    logic               rz_pos;

    // Third stage: projection scale products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx   <= 33'($signed({1'b0, i_x_scale})) * 33'(i_view.px);
            r_my   <= 33'($signed({1'b0, i_y_scale})) * 33'(i_view.py);
            r_view <= i_view;
        end
    end

    // Fourth stage: split the signed divisions into magnitudes and quotient signs.
    always_comb begin
        sx     = r_mx[32:11];
        sy     = r_my[32:11];
        ax     = sx[21] ? 22'(-sx) : 22'(sx);
        ay     = sy[21] ? 22'(-sy) : 22'(sy);
        rz_pos = !r_view.rz[5] && !r_view.zero;

        n_pack.lx.work  = DIV_WIDTH'(ax);
        n_pack.lx.rem   = '0;
        n_pack.ly.work  = DIV_WIDTH'(ay);
        n_pack.ly.rem   = '0;
        n_pack.ld.work  = i_depth_num[31] ? (~i_depth_num + 32'd1) : i_depth_num;
        n_pack.ld.rem   = '0;
        n_pack.ctl.dvs  = r_view.rz[5] ? 6'(-r_view.rz) : 6'(r_view.rz);
        // Screen coordinates divide by the negated depth.
        n_pack.ctl.neg_x = sx[21] ^ rz_pos;
        n_pack.ctl.neg_y = sy[21] ^ rz_pos;
        n_pack.ctl.neg_d = i_depth_num[31] ^ r_view.rz[5];
        n_pack.ctl.zero  = r_view.zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pack <= n_pack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
        end
    end

    assign o_vld  = r_vld4;
    assign o_pack = r_pack;

endmodule
`default_nettype wire

@@ rtl/vtp_div_stage.sv @@
`default_nettype none
module vtp_div_stage
    import vtp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire t_div_pack i_pack,
    output logic           o_vld,
    output t_div_pack      o_pack
);

    logic      r_vld;
    t_div_pack r_pack;
    t_div_pack n_pack;

    // Restoring long division, DIV_BITS quotient bits shifted into the low end.
    function automatic t_div_lane div_step(input t_div_lane a, input logic [5:0] d);
        logic [5:0] t;
        t_div_lane  r;
        r = a;
        for (int i = 0; i < DIV_BITS; i++) begin
            t      = {r.rem, r.work[DIV_WIDTH-1]};
            r.work = {r.work[DIV_WIDTH-2:0], (t >= d)};
            if (t >= d) begin
                t = t - d;
            end
            r.rem = t[4:0];
        end
        return r;
    endfunction

    always_comb begin
        n_pack     = i_pack;
        n_pack.lx  = div_step(i_pack.lx, i_pack.ctl.dvs);
        n_pack.ly  = div_step(i_pack.ly, i_pack.ctl.dvs);
        n_pack.ld  = div_step(i_pack.ld, i_pack.ctl.dvs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pack <= n_pack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    assign o_vld  = r_vld;
    assign o_pack = r_pack;

`ifndef SYNTHESIS
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ((r_pack.ctl.dvs == 6'd0) == r_pack.ctl.zero))
        else $error("divisor magnitude disagrees with zero-depth flag");
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_pack.ctl.zero |-> ({1'b0, r_pack.lx.rem} < r_pack.ctl.dvs))
        else $error("x remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_pack.ctl.zero |-> ({1'b0, r_pack.ly.rem} < r_pack.ctl.dvs))
        else $error("y remainder not below divisor");
    a_rem_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_pack.ctl.zero |-> ({1'b0, r_pack.ld.rem} < r_pack.ctl.dvs))
        else $error("depth remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ rtl/vertex_transform_project.sv @@
// A vertex transferred in passes through two rotation stages, two scale stages, four
// divider stages and the output register.
// Throughput: one vertex per cycle; the whole pipeline advances whenever the output
// register is empty or being taken. Reset (synchronous, active low) empties the
// pipeline and loads the identity rotation, zero translation and scales of 1.
`default_nettype none
module vertex_transform_project
    import vtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    vtp_vert_if.sink         i_vert,
    vtp_proj_if.source       o_proj,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data
);

    logic [47:0] r_rot_x;
    logic [47:0] r_rot_y;
    logic [47:0] r_rot_z;
    logic [47:0] r_trans;
    logic [15:0] r_x_scale;
    logic [15:0] r_y_scale;
    logic [31:0] r_depth_ofs;
    logic [31:0] r_depth_num;

    logic        en;
    logic        rot_vld;
    t_view       rot_view;
    logic        div_vld  [DIV_STAGES+1];
    t_div_pack   div_pack [DIV_STAGES+1];
    t_div_pack   last;

    logic               r_out_vld;
    logic signed [15:0] r_screen_x;
    logic signed [15:0] r_screen_y;
    logic signed [15:0] r_depth_out;
    logic               r_depth_zero;
    logic signed [15:0] n_screen_x;
    logic signed [15:0] n_screen_y;
    logic signed [15:0] n_depth_out;
    logic        [15:0] qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x     <= ROT_X_RESET;
            r_rot_y     <= ROT_Y_RESET;
            r_rot_z     <= ROT_Z_RESET;
            r_trans     <= '0;
            r_x_scale   <= 16'd1;
            r_y_scale   <= 16'd1;
            r_depth_ofs <= '0;
            r_depth_num <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_X:     r_rot_x     <= i_cfg_data;
                REG_ROT_Y:     r_rot_y     <= i_cfg_data;
                REG_ROT_Z:     r_rot_z     <= i_cfg_data;
                REG_TRANS:     r_trans     <= i_cfg_data;
                REG_X_SCALE:   r_x_scale   <= i_cfg_data[15:0];
                REG_Y_SCALE:   r_y_scale   <= i_cfg_data[15:0];
                REG_DEPTH_OFS: r_depth_ofs <= i_cfg_data[31:0];
                REG_DEPTH_NUM: r_depth_num <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign en           = !r_out_vld || o_proj.ready;
    assign i_vert.ready = en;

    vtp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_vert.valid),
        .i_x     (i_vert.vert_x),
        .i_y     (i_vert.vert_y),
        .i_z     (i_vert.vert_z),
        .i_row_x (r_rot_x),
        .i_row_y (r_rot_y),
        .i_row_z (r_rot_z),
        .i_trans (r_trans),
        .o_vld   (rot_vld),
        .o_view  (rot_view)
    );

    vtp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (rot_vld),
        .i_view      (rot_view),
        .i_x_scale   (r_x_scale),
        .i_y_scale   (r_y_scale),
        .i_depth_num (r_depth_num),
        .o_vld       (div_vld[0]),
        .o_pack      (div_pack[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        vtp_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (div_vld[g]),
            .i_pack  (div_pack[g]),
            .o_vld   (div_vld[g+1]),
            .o_pack  (div_pack[g+1])
        );
    end

    // Apply quotient signs and depth offset on 16 bits; zero depth gives zeros.
    always_comb begin
        last       = div_pack[DIV_STAGES];
        n_screen_x = last.ctl.neg_x ? -last.lx.work[15:0] : last.lx.work[15:0];
        n_screen_y = last.ctl.neg_y ? -last.ly.work[15:0] : last.ly.work[15:0];
        qd         = last.ctl.neg_d ? -last.ld.work[15:0] : last.ld.work[15:0];
        n_depth_out = r_depth_ofs[15:0] + qd;
        if (last.ctl.zero) begin
            n_screen_x  = '0;
            n_screen_y  = '0;
            n_depth_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_screen_x   <= n_screen_x;
            r_screen_y   <= n_screen_y;
            r_depth_out  <= n_depth_out;
            r_depth_zero <= last.ctl.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld[DIV_STAGES];
        end
    end

    assign o_proj.valid      = r_out_vld;
    assign o_proj.screen_x   = r_screen_x;
    assign o_proj.screen_y   = r_screen_y;
    assign o_proj.depth_out  = r_depth_out;
    assign o_proj.depth_zero = r_depth_zero;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid && !o_proj.ready |-> !i_vert.ready)
        else $error("input taken while output is stalled");
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid && o_proj.depth_zero |->
            (o_proj.screen_x == 16'sd0) && (o_proj.screen_y == 16'sd0)
            && (o_proj.depth_out == 16'sd0))
        else $error("zero-depth result carries nonzero fields");
    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid && !o_proj.ready |=> o_proj.valid && $stable(r_depth_zero))
        else $error("stalled result lost or changed");
`endif

endmodule
`default_nettype wire

@@ verif/vertex_transform_project_tb.sv @@
`timescale 1ns / 1ps
module vertex_transform_project_tb;
    import vtp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [3:0] IDX_PAST_LAST = REG_DEPTH_NUM + 4'd1;
    localparam logic [3:0] IDX_TOP       = 4'hF;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] depth;
        logic               zero;
    } proj_t;

    class vertex_projection_checker;
        logic [47:0] rot_x, rot_y, rot_z, trans;
        logic [15:0] x_scale, y_scale;
        logic [31:0] depth_ofs, depth_num;
        proj_t       projected_q[$];
        int          mismatches;

        function new();
            rot_x      = ROT_X_RESET;
            rot_y      = ROT_Y_RESET;
            rot_z      = ROT_Z_RESET;
            trans      = '0;
            x_scale    = 16'd1;
            y_scale    = 16'd1;
            depth_ofs  = '0;
            depth_num  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [47:0] data);
            case (idx)
                REG_ROT_X:     rot_x = data;
                REG_ROT_Y:     rot_y = data;
                REG_ROT_Z:     rot_z = data;
                REG_TRANS:     trans = data;
                REG_X_SCALE:   x_scale = data[15:0];
                REG_Y_SCALE:   y_scale = data[15:0];
                REG_DEPTH_OFS: depth_ofs = data[31:0];
                REG_DEPTH_NUM: depth_num = data[31:0];
                default: ;
            endcase
        endfunction

        function longint wrap16(longint v);
            logic signed [15:0] w;
            w = v[15:0];
            return longint'(w);
        endfunction

        function longint rotate_row(logic [47:0] row, longint x, longint y, longint z,
                                    int sh);
            longint acc;
            acc = x * longint'($signed(row[15:0])) + y * longint'($signed(row[31:16]))
                + z * longint'($signed(row[47:32])) * 4;
            return acc >>> sh;
        endfunction

        function proj_t project_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z);
            longint px, py, pz, rz, sx, sy, d;
            proj_t  r;
            px = wrap16(rotate_row(rot_x, x, y, z, 14) + longint'($signed(trans[15:0])) * 2048);
            py = wrap16(rotate_row(rot_y, x, y, z, 14) + longint'($signed(trans[31:16])) * 2048);
            pz = wrap16(rotate_row(rot_z, x, y, z, 16) + longint'($signed(trans[47:32])) * 512
                        - longint'(TZ_BIAS));
            rz = pz >>> 10;
            if (rz == 0) begin
                r = '{sx: '0, sy: '0, depth: '0, zero: 1'b1};
            end else begin
                sx = ((longint'(x_scale) * px) >>> 11) / (-rz);
                sy = ((longint'(y_scale) * py) >>> 11) / (-rz);
                // The quotient is taken at full width; only the sum wraps.
                d  = longint'($signed(depth_ofs)) + longint'($signed(depth_num)) / rz;
                r  = '{sx: sx[15:0], sy: sy[15:0], depth: d[15:0], zero: 1'b0};
            end
            return r;
        endfunction

        function void note_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
            projected_q.push_back(project_vertex(x, y, z));
        endfunction

        function void check_projection(proj_t got);
            proj_t exp_p;
            if (projected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: x=%0d y=%0d depth=%0d zero=%0b",
                             got.sx, got.sy, got.depth, got.zero);
                return;
            end
            exp_p = projected_q.pop_front();
            if (got.sx !== exp_p.sx || got.sy !== exp_p.sy || got.depth !== exp_p.depth
                    || got.zero !== exp_p.zero) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected x=%0d y=%0d depth=%0d zero=%0b, got x=%0d y=%0d depth=%0d zero=%0b",
                             exp_p.sx, exp_p.sy, exp_p.depth, exp_p.zero,
                             got.sx, got.sy, got.depth, got.zero);
            end
        endfunction

        function int pending();
            return projected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_idx = '0;
    logic [47:0] i_cfg_data = '0;

    vtp_vert_if vert_ch();
    vtp_proj_if proj_ch();

    vertex_projection_checker sb = new();

    int tx_idle_pct = 30;
    int rx_idle_pct = 53;
    int rx_hold_cycles = 0;
    int cycle_count = 0;

    vertex_transform_project dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vert     (vert_ch),
        .o_proj     (proj_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        vert_ch.valid  = 1'b0;
        vert_ch.vert_x = '0;
        vert_ch.vert_y = '0;
        vert_ch.vert_z = '0;
        proj_ch.ready  = 1'b0;
    end

    // Output side: a long hold-off, when requested, takes priority over random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            proj_ch.ready  <= 1'b0;
        end else begin
            proj_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && proj_ch.valid && proj_ch.ready)
            sb.check_projection('{sx: proj_ch.screen_x, sy: proj_ch.screen_y,
                                  depth: proj_ch.depth_out, zero: proj_ch.depth_zero});
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            vert_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        vert_ch.valid  <= 1'b1;
        vert_ch.vert_x <= x;
        vert_ch.vert_y <= y;
        vert_ch.vert_z <= z;
        do @(posedge i_clk); while (!vert_ch.ready);
        sb.note_vertex(x, y, z);
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        vert_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Leaves the enable high; end_writes closes a burst of writes.
    task automatic write_reg(input logic [3:0] idx, input logic [47:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [15:0] tame_coeff();
        return 16'($urandom_range(32768) - 32'd16384);
    endfunction

    task automatic random_setup(input bit tame);
        if (tame) begin
            write_reg(REG_ROT_X, {tame_coeff(), tame_coeff(), tame_coeff()});
            write_reg(REG_ROT_Y, {tame_coeff(), tame_coeff(), tame_coeff()});
            write_reg(REG_ROT_Z, {tame_coeff(), tame_coeff(), tame_coeff()});
            write_reg(REG_TRANS, {16'($urandom_range(64) - 32'd32), 32'($urandom)});
            write_reg(REG_X_SCALE, 48'($urandom_range(4096)));
            write_reg(REG_Y_SCALE, 48'($urandom_range(4096)));
        end else begin
            write_reg(REG_ROT_X, rand48());
            write_reg(REG_ROT_Y, rand48());
            write_reg(REG_ROT_Z, rand48());
            write_reg(REG_TRANS, rand48());
            write_reg(REG_X_SCALE, rand48());
            write_reg(REG_Y_SCALE, rand48());
        end
        write_reg(REG_DEPTH_OFS, rand48());
        write_reg(REG_DEPTH_NUM, rand48());
        if ($urandom_range(1) == 1)
            write_reg(4'($urandom_range(IDX_TOP, IDX_PAST_LAST)), rand48());
        end_writes();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: identity rotation, so depth follows z minus the bias.
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h7FFF, 16'h8000, 16'h0000);
        send_vertex(16'h8000, 16'h7FFF, 16'hFFFF);
        send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_vertex(16'h0001, 16'h0001, 16'h0001);
        // View depth of exactly zero at both ends of its band, and just outside it.
        send_vertex(16'd100, -16'sd100, 16'd12288);
        send_vertex(16'd5, 16'd5, 16'd13311);
        send_vertex(16'd5, 16'd5, 16'd12287);
        send_vertex(16'd5, 16'd5, 16'd13312);
        drain_pipeline();

        // Wide data on narrow registers, writes past the last index, and a depth
        // quotient that only fits in wide arithmetic.
        write_reg(REG_X_SCALE, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_Y_SCALE, 48'hABCD_0000);
        write_reg(REG_DEPTH_OFS, 48'hFFFF_7FFF_FFFF);
        write_reg(REG_DEPTH_NUM, 48'h0000_8000_0000);
        write_reg(IDX_PAST_LAST, 48'hFFFF_FFFF_FFFF);
        write_reg(IDX_TOP, 48'hFFFF_FFFF_FFFF);
        end_writes();
        send_vertex(16'h7FFF, 16'h8000, 16'd12287);
        send_vertex(16'h8000, 16'h7FFF, 16'd13312);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h8000);
        send_vertex(16'h8000, 16'h8000, 16'h7FFF);
        send_vertex(16'h1234, 16'h5678, 16'd12800);
        send_vertex(16'hFFFF, 16'h0001, 16'd11264);
        drain_pipeline();

        write_reg(REG_ROT_X, 48'h8000_8000_8000);
        write_reg(REG_ROT_Y, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_ROT_Z, 48'h8000_7FFF_0001);
        write_reg(REG_TRANS, 48'h8000_7FFF_8000);
        end_writes();
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h8000, 16'h7FFF, 16'h8000);
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h0001, 16'hFFFF, 16'h4000);
        send_vertex(16'hAAAA, 16'h5555, 16'hC000);
        drain_pipeline();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 2) begin
                tx_idle_pct = 30;
                rx_idle_pct = 53;
            end else if (phase < 4) begin
                tx_idle_pct = 53;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_setup(phase % 2 == 0);
            // With the sender running flat out, this backs the pipeline up to its input.
            if (phase == 5)
                rx_hold_cycles = 400;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
            drain_pipeline();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/vtp_pkg.sv
rtl/vtp_vert_if.sv
rtl/vtp_proj_if.sv
rtl/vtp_rotate.sv
rtl/vtp_scale.sv
rtl/vtp_div_stage.sv
rtl/vertex_transform_project.sv
verif/vertex_transform_project_tb.sv
